// File: hw/rtl/jssd_pkg.sv
// shared types, constants and index helpers for the job-shop schedule decoder
// no dependencies; imported by every module of the block
package jssd_pkg;

  localparam int NumJobs     = 16;
  localparam int OpsPerJob   = 8;
  localparam int NumMachines = 8;
  localparam int TimeBitsDef = 20;

  localparam int FuncW = 2;
  localparam int JobW  = 4;
  localparam int OpW   = 3;
  localparam int MachW = 3;
  localparam int DurW  = 13;
  localparam int ErrW  = 2;

  localparam int JobIdxW   = $clog2(NumJobs);
  localparam int MachIdxW  = $clog2(NumMachines);
  localparam int CntW      = $clog2(OpsPerJob + 1);
  localparam int AssignDep = NumJobs * OpsPerJob;
  localparam int AssignAw  = $clog2(AssignDep);
  localparam int DurDep    = NumJobs * OpsPerJob * NumMachines;
  localparam int DurAw     = $clog2(DurDep);

  localparam logic [FuncW-1:0] FuncLoadAssign = 2'd0;
  localparam logic [FuncW-1:0] FuncLoadDur    = 2'd1;
  localparam logic [FuncW-1:0] FuncSchedule   = 2'd2;

  localparam logic [ErrW-1:0] ErrNone       = 2'd0;
  localparam logic [ErrW-1:0] ErrInfeasible = 2'd1;
  localparam logic [ErrW-1:0] ErrExhausted  = 2'd2;
  localparam logic [ErrW-1:0] ErrOverflow   = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_MACH,
    ST_RD_DUR
  } state_e;

  typedef struct packed {
    logic accept;
    logic read_dur;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sched_req;
  } ctrl_sts_t;

  function automatic logic [AssignAw-1:0] assign_addr(logic [JobW-1:0] job,
                                                      logic [CntW-1:0] op);
    int a;
    a = int'(job) * OpsPerJob + int'(op);
    return a[AssignAw-1:0];
  endfunction

  function automatic logic [DurAw-1:0] dur_addr(logic [JobW-1:0] job,
                                                logic [CntW-1:0] op,
                                                logic [MachW-1:0] mach);
    int a;
    a = (int'(job) * OpsPerJob + int'(op)) * NumMachines + int'(mach);
    return a[DurAw-1:0];
  endfunction

endpackage

// File: hw/rtl/job_shop_schedule_decoder.sv
// top level of the flexible job-shop schedule decoder
// depends on jssd_pkg, jssd_ctrl and jssd_datapath
//
// usage:
//   a request is taken at a rising edge with start high and busy low.
//   func selects: load machine assignment, load duration entry, or schedule
//   the named job's next operation. func 3 and out-of-range indexes are ignored.
//   load requests give no result; busy stays low.
//   a schedule request sets busy through the machine and duration lookup
//   states: the assignment table is read at the accepting edge, the duration
//   table at the end of the machine lookup state, and the ready times update
//   at the end of the duration lookup state. the result is registered there
//   and shown for one cycle with valid_o high; the next request is taken no
//   earlier than the edge that ends that cycle, so requests never overlap.
//   the result cannot be held off; valid_o lasts exactly one cycle.
//   reset clears ready times, operation counters and the sequencer; both
//   tables must be loaded before a schedule request reads them.
module job_shop_schedule_decoder #(
  parameter int TIME_BITS = jssd_pkg::TimeBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [jssd_pkg::FuncW-1:0]       func_i,
  input  logic [jssd_pkg::JobW-1:0]        job_id_i,
  input  logic [jssd_pkg::OpW-1:0]         op_number_i,
  input  logic [jssd_pkg::MachW-1:0]       machine_id_i,
  input  logic signed [jssd_pkg::DurW-1:0] duration_i,
  output logic                             valid_o,
  output logic [jssd_pkg::JobW-1:0]        out_job_o,
  output logic [jssd_pkg::OpW-1:0]         out_op_o,
  output logic [jssd_pkg::MachW-1:0]       out_machine_o,
  output logic [TIME_BITS-1:0]             start_time_o,
  output logic [TIME_BITS-1:0]             end_time_o,
  output logic [jssd_pkg::ErrW-1:0]        error_o
);
  import jssd_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  jssd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  jssd_datapath #(
    .TimeBits (TIME_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .func_i        (func_i),
    .job_id_i      (job_id_i),
    .op_number_i   (op_number_i),
    .machine_id_i  (machine_id_i),
    .duration_i    (duration_i),
    .out_job_o     (out_job_o),
    .out_op_o      (out_op_o),
    .out_machine_o (out_machine_o),
    .start_time_o  (start_time_o),
    .end_time_o    (end_time_o),
    .error_o       (error_o),
    .valid_o       (valid_o)
  );

  a_valid_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy))
    else $error("result strobe without a schedule request in flight");

  a_sched_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && sts.sched_req) |=> busy)
    else $error("schedule request did not start the sequencer");

  a_ok_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && error_o == ErrNone) |-> (end_time_o >= start_time_o))
    else $error("end time before start time");

  a_exhausted_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && error_o == ErrExhausted) |-> (start_time_o == '0 && end_time_o == '0))
    else $error("exhausted job reported nonzero times");

endmodule

// File: hw/rtl/jssd_ctrl.sv
// sequencer for the schedule decoder: idle, machine lookup, duration lookup
// depends on jssd_pkg; drives the datapath through command and status structs
module jssd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  jssd_pkg::ctrl_sts_t sts_i,
  output jssd_pkg::ctrl_cmd_t cmd_o
);
  import jssd_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start && sts_i.sched_req) state_d = ST_RD_MACH;
      end
      ST_RD_MACH: state_d = ST_RD_DUR;
      ST_RD_DUR:  state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy           = 1'b1;
    cmd_o.accept   = 1'b0;
    cmd_o.read_dur = 1'b0;
    cmd_o.finish   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy         = 1'b0;
        cmd_o.accept = start;
      end
      ST_RD_MACH: cmd_o.read_dur = 1'b1;
      ST_RD_DUR:  cmd_o.finish   = 1'b1;
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// File: hw/rtl/jssd_datapath.sv
// tables, ready times, operation counters and result registers
// depends on jssd_pkg; sequenced by jssd_ctrl
module jssd_datapath #(
  parameter int TimeBits = jssd_pkg::TimeBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  jssd_pkg::ctrl_cmd_t           cmd_i,
  output jssd_pkg::ctrl_sts_t           sts_o,
  input  logic [jssd_pkg::FuncW-1:0]    func_i,
  input  logic [jssd_pkg::JobW-1:0]     job_id_i,
  input  logic [jssd_pkg::OpW-1:0]      op_number_i,
  input  logic [jssd_pkg::MachW-1:0]    machine_id_i,
  input  logic signed [jssd_pkg::DurW-1:0] duration_i,
  output logic [jssd_pkg::JobW-1:0]     out_job_o,
  output logic [jssd_pkg::OpW-1:0]      out_op_o,
  output logic [jssd_pkg::MachW-1:0]    out_machine_o,
  output logic [TimeBits-1:0]           start_time_o,
  output logic [TimeBits-1:0]           end_time_o,
  output logic [jssd_pkg::ErrW-1:0]     error_o,
  output logic                          valid_o
);
  import jssd_pkg::*;

  localparam int SumW = ((TimeBits > DurW - 1) ? TimeBits : DurW - 1) + 1;
  localparam logic [SumW-1:0] MaxTime = SumW'({TimeBits{1'b1}});

  logic [MachW-1:0] assign_mem [AssignDep];
  logic [DurW-1:0]  dur_mem    [DurDep];

  logic [TimeBits-1:0] job_ready_q  [NumJobs];
  logic [TimeBits-1:0] mach_ready_q [NumMachines];
  logic [CntW-1:0]     next_op_q    [NumJobs];

  logic [JobW-1:0]  job_q;
  logic [CntW-1:0]  cur_q;
  logic [MachW-1:0] assign_rd_q;
  logic [DurW-1:0]  dur_rd_q;

  logic [JobW-1:0]     out_job_q;
  logic [OpW-1:0]      out_op_q;
  logic [MachW-1:0]    out_mach_q;
  logic [TimeBits-1:0] start_q, end_q;
  logic [ErrW-1:0]     err_q;
  logic                valid_q;

  logic load_assign, load_dur, job_ok;
  logic [CntW-1:0] cur_in;
  logic exhausted, bad_mach, bad_dur, overflow, commit;
  logic [TimeBits-1:0] job_rdy, mach_rdy, st;
  logic [SumW-1:0] sum;

  assign job_ok = int'(job_id_i) < NumJobs;
  assign sts_o.sched_req = (func_i == FuncSchedule) && job_ok;

  assign load_assign = cmd_i.accept && (func_i == FuncLoadAssign) && job_ok
                       && (int'(op_number_i) < OpsPerJob);
  assign load_dur    = cmd_i.accept && (func_i == FuncLoadDur) && job_ok
                       && (int'(op_number_i) < OpsPerJob)
                       && (int'(machine_id_i) < NumMachines);

  assign cur_in = next_op_q[job_id_i[JobIdxW-1:0]];

  always_ff @(posedge clk_i) begin
    if (load_assign) begin
      assign_mem[assign_addr(job_id_i, CntW'(op_number_i))] <= machine_id_i;
    end
    if (cmd_i.accept && sts_o.sched_req) begin
      assign_rd_q <= assign_mem[assign_addr(job_id_i, cur_in)];
      job_q       <= job_id_i;
      cur_q       <= cur_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_dur) begin
      dur_mem[dur_addr(job_id_i, CntW'(op_number_i), machine_id_i)] <= duration_i;
    end
    if (cmd_i.read_dur) begin
      dur_rd_q <= dur_mem[dur_addr(job_q, cur_q, assign_rd_q)];
    end
  end

  always_comb begin
    exhausted = int'(cur_q) >= OpsPerJob;
    bad_mach  = int'(assign_rd_q) >= NumMachines;
    bad_dur   = dur_rd_q[DurW-1];
    job_rdy   = job_ready_q[job_q[JobIdxW-1:0]];
    mach_rdy  = mach_ready_q[assign_rd_q[MachIdxW-1:0]];
    st        = (mach_rdy > job_rdy) ? mach_rdy : job_rdy;
    sum       = SumW'(st) + SumW'(dur_rd_q[DurW-2:0]);
    overflow  = sum > MaxTime;
    commit    = cmd_i.finish && !exhausted && !bad_mach && !bad_dur && !overflow;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumJobs; i++) begin
        job_ready_q[i] <= '0;
        next_op_q[i]   <= '0;
      end
      for (int i = 0; i < NumMachines; i++) begin
        mach_ready_q[i] <= '0;
      end
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.finish;
      if (commit) begin
        job_ready_q[job_q[JobIdxW-1:0]]         <= sum[TimeBits-1:0];
        mach_ready_q[assign_rd_q[MachIdxW-1:0]] <= sum[TimeBits-1:0];
        next_op_q[job_q[JobIdxW-1:0]]           <= cur_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_job_q <= job_q;
      if (exhausted) begin
        out_op_q   <= '0;
        out_mach_q <= '0;
        start_q    <= '0;
        end_q      <= '0;
        err_q      <= ErrExhausted;
      end else if (bad_mach || bad_dur) begin
        out_op_q   <= cur_q[OpW-1:0];
        out_mach_q <= assign_rd_q;
        start_q    <= '0;
        end_q      <= '0;
        err_q      <= ErrInfeasible;
      end else if (overflow) begin
        out_op_q   <= cur_q[OpW-1:0];
        out_mach_q <= assign_rd_q;
        start_q    <= st;
        end_q      <= {TimeBits{1'b1}};
        err_q      <= ErrOverflow;
      end else begin
        out_op_q   <= cur_q[OpW-1:0];
        out_mach_q <= assign_rd_q;
        start_q    <= st;
        end_q      <= sum[TimeBits-1:0];
        err_q      <= ErrNone;
      end
    end
  end

  assign out_job_o     = out_job_q;
  assign out_op_o      = out_op_q;
  assign out_machine_o = out_mach_q;
  assign start_time_o  = start_q;
  assign end_time_o    = end_q;
  assign error_o       = err_q;
  assign valid_o       = valid_q;

endmodule

// File: tb/sv/job_shop_schedule_decoder_tb.sv
// self-checking testbench for job_shop_schedule_decoder: table loads, schedule requests
// and ignored requests, checked against a predictor of the ready times and op counters
// depends on jssd_pkg and the job_shop_schedule_decoder rtl
module job_shop_schedule_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jssd_pkg::*;

  localparam int TimeW = TimeBitsDef;
  localparam logic [TimeW-1:0] TimeMax = '1;
  localparam logic [FuncW-1:0] FuncUnused = 2'd3;
  localparam int RandItems = 1800;

  typedef struct packed {
    logic [JobW-1:0]  job;
    logic [OpW-1:0]   op;
    logic [MachW-1:0] mach;
    logic [TimeW-1:0] start_at;
    logic [TimeW-1:0] end_at;
    logic [ErrW-1:0]  err;
  } sched_result_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [FuncW-1:0]        func_i;
  logic [JobW-1:0]         job_id_i;
  logic [OpW-1:0]          op_number_i;
  logic [MachW-1:0]        machine_id_i;
  logic signed [DurW-1:0]  duration_i;
  logic                    valid_o;
  logic [JobW-1:0]         out_job_o;
  logic [OpW-1:0]          out_op_o;
  logic [MachW-1:0]        out_machine_o;
  logic [TimeW-1:0]        start_time_o;
  logic [TimeW-1:0]        end_time_o;
  logic [ErrW-1:0]         error_o;

  sched_result_t expected_results[$];

  logic [TimeW-1:0] job_ready[NumJobs];
  logic [TimeW-1:0] mach_ready[NumMachines];
  logic [CntW-1:0]  next_op[NumJobs];
  logic [MachW-1:0] assign_tbl[AssignDep];
  logic [DurW-1:0]  dur_tbl[DurDep];
  bit               assign_loaded[AssignDep];
  bit               dur_loaded[DurDep];

  int mismatch_count = 0;
  int request_count = 0;
  int calm_left = 0;

  job_shop_schedule_decoder #(
    .TIME_BITS(TimeW)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .func_i       (func_i),
    .job_id_i     (job_id_i),
    .op_number_i  (op_number_i),
    .machine_id_i (machine_id_i),
    .duration_i   (duration_i),
    .valid_o      (valid_o),
    .out_job_o    (out_job_o),
    .out_op_o     (out_op_o),
    .out_machine_o(out_machine_o),
    .start_time_o (start_time_o),
    .end_time_o   (end_time_o),
    .error_o      (error_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic void apply_request(input logic [FuncW-1:0] func,
                                        input logic [JobW-1:0] job,
                                        input logic [OpW-1:0] op,
                                        input logic [MachW-1:0] mach,
                                        input logic [DurW-1:0] dur);
    int slot;
    logic [MachW-1:0] m;
    logic [DurW-1:0] d;
    logic [TimeW:0] sum;
    sched_result_t r;
    slot = int'(job) * OpsPerJob + int'(op);
    case (func)
      FuncLoadAssign: begin
        assign_tbl[slot] = mach;
        assign_loaded[slot] = 1'b1;
      end
      FuncLoadDur: begin
        dur_tbl[slot * NumMachines + int'(mach)] = dur;
        dur_loaded[slot * NumMachines + int'(mach)] = 1'b1;
      end
      FuncSchedule: begin
        r = '0;
        r.job = job;
        if (next_op[job] >= OpsPerJob) begin
          r.err = ErrExhausted;
        end else begin
          slot = int'(job) * OpsPerJob + int'(next_op[job]);
          m = assign_tbl[slot];
          r.op = next_op[job][OpW-1:0];
          r.mach = m;
          if (int'(m) >= NumMachines) begin
            r.err = ErrInfeasible;
          end else begin
            d = dur_tbl[slot * NumMachines + int'(m)];
            if (d[DurW-1]) begin
              r.err = ErrInfeasible;
            end else begin
              r.start_at = (mach_ready[m] > job_ready[job]) ? mach_ready[m] : job_ready[job];
              sum = r.start_at + d;
              if (sum > TimeMax) begin
                r.end_at = TimeMax;
                r.err = ErrOverflow;
              end else begin
                r.end_at = sum[TimeW-1:0];
                r.err = ErrNone;
                job_ready[job] = r.end_at;
                mach_ready[m] = r.end_at;
                next_op[job] = next_op[job] + 1'b1;
              end
            end
          end
        end
        expected_results.push_back(r);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [DurW-1:0] draw_duration();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return '1;
    if (r < 40) return DurW'($urandom_range(0, 15));
    if (r < 45) return DurW'(4095);
    return DurW'($urandom_range(0, 4095));
  endfunction

  task automatic send_request(input logic [FuncW-1:0] func, input logic [JobW-1:0] job,
                              input logic [OpW-1:0] op, input logic [MachW-1:0] mach,
                              input logic [DurW-1:0] dur);
    int gap;
    if (calm_left > 0) begin
      gap = 0;
      calm_left--;
    end else if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(8, 48);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 17);
    end
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start        <= 1'b1;
    func_i       <= func;
    job_id_i     <= job;
    op_number_i  <= op;
    machine_id_i <= mach;
    duration_i   <= dur;
    do @(posedge clk_i); while (busy);
    apply_request(func, job, op, mach, dur);
    if (func != FuncUnused) request_count++;
  endtask

  task automatic wait_for_results();
    int waited;
    waited = 0;
    @(negedge clk_i);
    start <= 1'b0;
    while (expected_results.size() != 0 && waited < 200) begin
      @(posedge clk_i);
      waited++;
    end
  endtask

  // loads whatever the job's next operation still lacks (now and then reloads it anyway), then schedules it
  task automatic schedule_next_op(input logic [JobW-1:0] job);
    int slot;
    logic [MachW-1:0] m;
    if (next_op[job] < OpsPerJob) begin
      slot = int'(job) * OpsPerJob + int'(next_op[job]);
      if (!assign_loaded[slot] || $urandom_range(0, 4) == 0)
        send_request(FuncLoadAssign, job, next_op[job][OpW-1:0],
                     MachW'($urandom_range(0, NumMachines - 1)), draw_duration());
      m = assign_tbl[slot];
      if (!dur_loaded[slot * NumMachines + int'(m)] || $urandom_range(0, 3) == 0)
        send_request(FuncLoadDur, job, next_op[job][OpW-1:0], m, draw_duration());
    end
    send_request(FuncSchedule, job, OpW'($urandom_range(0, 7)), MachW'($urandom_range(0, 7)),
                 draw_duration());
  endtask

  task automatic test_load_extremes();
    send_request(FuncLoadAssign, 4'd0, 3'd0, 3'd7, '0);
    send_request(FuncLoadDur, 4'd0, 3'd0, 3'd7, DurW'(4095));
    send_request(FuncLoadAssign, 4'd15, 3'd7, 3'd0, '1);
    send_request(FuncLoadDur, 4'd15, 3'd7, 3'd0, '0);
  endtask

  // second job waits for the machine held by the first
  task automatic test_machine_contention();
    send_request(FuncSchedule, 4'd0, 3'd7, 3'd7, '1);
    send_request(FuncLoadAssign, 4'd1, 3'd0, 3'd7, '0);
    send_request(FuncLoadDur, 4'd1, 3'd0, 3'd7, DurW'(1));
    send_request(FuncSchedule, 4'd1, 3'd0, 3'd0, '0);
  endtask

  task automatic test_infeasible_duration();
    send_request(FuncLoadAssign, 4'd2, 3'd0, 3'd3, '0);
    send_request(FuncLoadDur, 4'd2, 3'd0, 3'd3, '1);
    send_request(FuncSchedule, 4'd2, 3'd0, 3'd0, '0);
    send_request(FuncLoadDur, 4'd2, 3'd0, 3'd3, '0);
    send_request(FuncSchedule, 4'd2, 3'd5, 3'd2, DurW'(7));
  endtask

  task automatic test_unused_func();
    send_request(FuncUnused, 4'd15, 3'd7, 3'd7, '1);
    send_request(FuncUnused, 4'd0, 3'd0, 3'd0, '0);
    schedule_next_op(4'd2);
  endtask

  task automatic test_ops_exhausted();
    while (next_op[15] < OpsPerJob) schedule_next_op(4'd15);
    schedule_next_op(4'd15);
    wait_for_results();
  endtask

  task automatic test_random_mix();
    int r;
    int first;
    bit paused;
    logic [JobW-1:0] job;
    first = request_count;
    paused = 1'b0;
    while (request_count - first < RandItems) begin
      if (!paused && request_count - first >= RandItems / 2) begin
        wait_for_results();
        paused = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
        job = JobW'($urandom_range(0, NumJobs - 1));
        if ($urandom_range(0, 4) != 0)
          for (int k = 0; k < NumJobs && next_op[job] >= OpsPerJob; k++) job = job + 1'b1;
        schedule_next_op(job);
      end else if (r < 78) begin
        send_request(FuncLoadAssign, JobW'($urandom_range(0, NumJobs - 1)),
                     OpW'($urandom_range(0, OpsPerJob - 1)),
                     MachW'($urandom_range(0, NumMachines - 1)), draw_duration());
      end else if (r < 96) begin
        send_request(FuncLoadDur, JobW'($urandom_range(0, NumJobs - 1)),
                     OpW'($urandom_range(0, OpsPerJob - 1)),
                     MachW'($urandom_range(0, NumMachines - 1)), draw_duration());
      end else begin
        send_request(FuncUnused, JobW'($urandom_range(0, 15)), OpW'($urandom_range(0, 7)),
                     MachW'($urandom_range(0, 7)), draw_duration());
      end
    end
  endtask

  always @(posedge clk_i) begin : check_results
    sched_result_t want;
    if (rst_ni && valid_o) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result for job %0d with no request outstanding",
                                  out_job_o));
      end else begin
        want = expected_results.pop_front();
        if (out_job_o !== want.job)
          report_mismatch($sformatf("out_job got %0d want %0d", out_job_o, want.job));
        if (out_op_o !== want.op)
          report_mismatch($sformatf("out_op got %0d want %0d", out_op_o, want.op));
        if (out_machine_o !== want.mach)
          report_mismatch($sformatf("out_machine got %0d want %0d", out_machine_o, want.mach));
        if (start_time_o !== want.start_at)
          report_mismatch($sformatf("start_time got %0d want %0d", start_time_o,
                                    want.start_at));
        if (end_time_o !== want.end_at)
          report_mismatch($sformatf("end_time got %0d want %0d", end_time_o, want.end_at));
        if (error_o !== want.err)
          report_mismatch($sformatf("error got %0d want %0d", error_o, want.err));
      end
    end
  end

  initial begin
    #2ms;
    $display("job_shop_schedule_decoder_tb failed");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    func_i       = '0;
    job_id_i     = '0;
    op_number_i  = '0;
    machine_id_i = '0;
    duration_i   = '0;
    foreach (job_ready[i]) job_ready[i] = '0;
    foreach (next_op[i]) next_op[i] = '0;
    foreach (mach_ready[i]) mach_ready[i] = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_load_extremes();
    test_machine_contention();
    test_infeasible_duration();
    test_unused_func();
    test_ops_exhausted();
    test_random_mix();
    wait_for_results();
    repeat (10) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived",
                                expected_results.size()));
    if (mismatch_count == 0) begin
      $display("job_shop_schedule_decoder_tb passed");
    end else begin
      $display("job_shop_schedule_decoder_tb failed");
    end
    $finish;
  end

endmodule
